FILE: src/round_robin_thread_picker_defines.svh
// ---------------------------------------------------------------------------
// Round robin thread picker assertion macros
// Concurrent assertion helpers, compiled out when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef ROUND_ROBIN_THREAD_PICKER_DEFINES_SVH
`define ROUND_ROBIN_THREAD_PICKER_DEFINES_SVH

`ifndef SYNTH
`define RRTP_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rrtp: implication check failed");
`define RRTP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rrtp: next-cycle check failed");
`else
`define RRTP_ASSERT_IMPL(label, ante, cons)
`define RRTP_ASSERT_NEXT(label, ante, cons)
`endif

`endif

FILE: src/rrtp_pkg.sv
// ---------------------------------------------------------------------------
// Round robin thread picker package
// Sizes, state and mode codes, payload types and control interface types.
// ---------------------------------------------------------------------------
package rrtp_pkg;

  localparam int SLOTS   = 64;
  localparam int SLOT_W  = $clog2(SLOTS);
  localparam int TICK_W  = 32;
  localparam int ID_W    = 6;
  localparam int CNT_W   = 16;
  localparam int TMO_W   = 32;
  localparam int STATE_W = 3;

  typedef logic [STATE_W-1:0] slot_state_t;
  typedef logic [1:0]         mode_t;

  localparam slot_state_t ST_EMPTY        = 3'd0;
  localparam slot_state_t ST_READY        = 3'd1;
  localparam slot_state_t ST_RUNNING      = 3'd2;
  localparam slot_state_t ST_BLOCKED      = 3'd3;
  localparam slot_state_t ST_WAIT_EVENT   = 3'd4;
  localparam slot_state_t ST_WAIT_TIMEOUT = 3'd5;

  localparam mode_t MODE_TICK   = 2'd0;
  localparam mode_t MODE_WRITE  = 2'd1;
  localparam mode_t MODE_SIGNAL = 2'd2;
  localparam mode_t MODE_SCHED  = 2'd3;

  typedef struct packed {
    mode_t             mode;
    logic [ID_W-1:0]   slot;
    slot_state_t       new_state;
    logic [TMO_W-1:0]  wait_timeout;
  } in_item_t;

  typedef struct packed {
    logic [ID_W-1:0] picked_slot;
    logic            went_idle;
  } out_item_t;

  typedef enum logic [2:0] {
    FSM_IDLE,
    FSM_SIGNAL,
    FSM_DEMOTE,
    FSM_SCAN,
    FSM_DONE
  } fsm_t;

  typedef struct packed {
    logic tick_inc;
    logic slot_wr;
    logic cnt_rd;
    logic cnt_inc;
    logic cur_rd;
    logic no_cur;
    logic demote;
    logic scan;
    logic push;
  } cmd_t;

  typedef struct packed {
    logic cur_valid;
    logic hit;
    logic last;
    logic out_full;
  } sts_t;

endpackage

FILE: src/rrtp_ram.sv
// ---------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module rrtp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/rrtp_ctrl.sv
// ---------------------------------------------------------------------------
// Round robin thread picker controller
// Sequences tick, slot write, event signal and schedule transactions.
// ---------------------------------------------------------------------------
module rrtp_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  rrtp_pkg::mode_t in_mode,
  output logic           in_ready,
  input  rrtp_pkg::sts_t sts,
  output rrtp_pkg::cmd_t cmd
);

  rrtp_pkg::fsm_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rrtp_pkg::FSM_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    cmd       = '0;
    unique case (state_r)
      rrtp_pkg::FSM_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          unique case (in_mode)
            rrtp_pkg::MODE_TICK: begin
              cmd.tick_inc = 1'b1;
            end
            rrtp_pkg::MODE_WRITE: begin
              cmd.slot_wr = 1'b1;
            end
            rrtp_pkg::MODE_SIGNAL: begin
              cmd.cnt_rd = 1'b1;
              state_nxt  = rrtp_pkg::FSM_SIGNAL;
            end
            rrtp_pkg::MODE_SCHED: begin
              if (sts.cur_valid) begin
                cmd.cur_rd = 1'b1;
                state_nxt  = rrtp_pkg::FSM_DEMOTE;
              end else begin
                cmd.no_cur = 1'b1;
                state_nxt  = rrtp_pkg::FSM_DONE;
              end
            end
            default: begin
            end
          endcase
        end
      end
      rrtp_pkg::FSM_SIGNAL: begin
        cmd.cnt_inc = 1'b1;
        state_nxt   = rrtp_pkg::FSM_IDLE;
      end
      rrtp_pkg::FSM_DEMOTE: begin
        cmd.demote = 1'b1;
        state_nxt  = rrtp_pkg::FSM_SCAN;
      end
      rrtp_pkg::FSM_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.hit || sts.last) begin
          state_nxt = rrtp_pkg::FSM_DONE;
        end
      end
      rrtp_pkg::FSM_DONE: begin
        if (!sts.out_full) begin
          cmd.push  = 1'b1;
          state_nxt = rrtp_pkg::FSM_IDLE;
        end
      end
      default: begin
        state_nxt = rrtp_pkg::FSM_IDLE;
      end
    endcase
  end

endmodule

FILE: src/rrtp_dp.sv
// ---------------------------------------------------------------------------
// Round robin thread picker datapath
// Slot tables, tick counter, circular scan and result register.
// ---------------------------------------------------------------------------
`include "round_robin_thread_picker_defines.svh"

module rrtp_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  rrtp_pkg::in_item_t            in_data,
  input  rrtp_pkg::cmd_t                cmd,
  output rrtp_pkg::sts_t                sts,
  input  logic                          cfg_we,
  input  logic [rrtp_pkg::ID_W-1:0]     cfg_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output rrtp_pkg::out_item_t           out_data
);

  localparam int TIM_W = rrtp_pkg::TICK_W + rrtp_pkg::TMO_W;

  logic [rrtp_pkg::ID_W-1:0]   idle_slot_r, idle_slot_nxt;
  logic [rrtp_pkg::ID_W-1:0]   cur_slot_r, cur_slot_nxt;
  logic                        cur_valid_r, cur_valid_nxt;
  logic [rrtp_pkg::TICK_W-1:0] tick_r, tick_nxt;
  logic [rrtp_pkg::SLOTS-1:0]  st_vld_r, st_vld_nxt;
  logic [rrtp_pkg::SLOTS-1:0]  cnt_vld_r, cnt_vld_nxt;
  logic                        st_vld_q_r, cnt_vld_q_r;
  logic [rrtp_pkg::SLOT_W-1:0] scan_idx_r, scan_idx_nxt;
  logic [rrtp_pkg::SLOT_W-1:0] scan_cnt_r, scan_cnt_nxt;
  logic [rrtp_pkg::SLOT_W-1:0] sig_slot_r, sig_slot_nxt;
  logic                        sig_ok_r, sig_ok_nxt;
  logic [rrtp_pkg::ID_W-1:0]   pick_r, pick_nxt;
  logic                        found_r, found_nxt;
  logic                        out_valid_r, out_valid_nxt;
  rrtp_pkg::out_item_t         out_data_r, out_data_nxt;

  rrtp_pkg::slot_state_t       st_q, st_eff, st_wdata, nst_norm;
  logic [rrtp_pkg::CNT_W-1:0]  cnt_q, cnt_eff, cnt_wdata;
  logic [TIM_W-1:0]            tim_q, tim_wdata;
  logic [rrtp_pkg::TICK_W-1:0] w_start, elapsed;
  logic [rrtp_pkg::TMO_W-1:0]  w_limit;
  logic [rrtp_pkg::SLOT_W-1:0] rd_addr, st_waddr, cnt_waddr;
  logic [rrtp_pkg::SLOT_W-1:0] in_addr, cur_addr, start_addr, next_idx;
  logic                        st_we, cnt_we, tim_we;
  logic                        in_slot_ok, cur_in, waiting, dec, hit, timed_out;

  rrtp_ram #(.WIDTH(rrtp_pkg::STATE_W), .DEPTH(rrtp_pkg::SLOTS)) u_state_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .raddr (rd_addr),
    .rdata (st_q)
  );

  rrtp_ram #(.WIDTH(rrtp_pkg::CNT_W), .DEPTH(rrtp_pkg::SLOTS)) u_count_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .raddr (rd_addr),
    .rdata (cnt_q)
  );

  rrtp_ram #(.WIDTH(TIM_W), .DEPTH(rrtp_pkg::SLOTS)) u_wait_ram (
    .clk   (clk),
    .we    (tim_we),
    .waddr (in_addr),
    .wdata (tim_wdata),
    .raddr (rd_addr),
    .rdata (tim_q)
  );

  always_comb begin
    in_addr    = rrtp_pkg::SLOT_W'(in_data.slot);
    in_slot_ok = int'(in_data.slot) < rrtp_pkg::SLOTS;
    cur_addr   = rrtp_pkg::SLOT_W'(cur_slot_r);
    cur_in     = int'(cur_slot_r) < rrtp_pkg::SLOTS;
    if (cur_in && (int'(cur_slot_r) + 1 < rrtp_pkg::SLOTS)) begin
      start_addr = rrtp_pkg::SLOT_W'(int'(cur_slot_r) + 1);
    end else begin
      start_addr = '0;
    end
    if (int'(scan_idx_r) == rrtp_pkg::SLOTS - 1) begin
      next_idx = '0;
    end else begin
      next_idx = scan_idx_r + rrtp_pkg::SLOT_W'(1);
    end

    // entries never written since reset read as empty with no events
    st_eff  = st_vld_q_r ? st_q : rrtp_pkg::ST_EMPTY;
    cnt_eff = cnt_vld_q_r ? cnt_q : '0;
    {w_start, w_limit} = tim_q;
    elapsed   = tick_r - w_start;
    timed_out = 64'(elapsed) >= 64'(w_limit);
    waiting   = (st_eff == rrtp_pkg::ST_WAIT_EVENT) || (st_eff == rrtp_pkg::ST_WAIT_TIMEOUT);
    dec       = waiting && (cnt_eff != '0);
    hit       = (st_eff == rrtp_pkg::ST_READY) || dec ||
                ((st_eff == rrtp_pkg::ST_WAIT_TIMEOUT) && timed_out);

    nst_norm = (in_data.new_state > rrtp_pkg::ST_WAIT_TIMEOUT) ? rrtp_pkg::ST_EMPTY
                                                              : in_data.new_state;

    priority if (cmd.cnt_rd) begin
      rd_addr = in_addr;
    end else if (cmd.demote) begin
      rd_addr = start_addr;
    end else if (cmd.scan) begin
      rd_addr = next_idx;
    end else begin
      rd_addr = cur_addr;
    end

    st_we    = 1'b0;
    st_waddr = in_addr;
    st_wdata = nst_norm;
    priority if (cmd.slot_wr && in_slot_ok) begin
      st_we = 1'b1;
    end else if (cmd.demote && cur_in && (cur_slot_r != idle_slot_r) &&
                 (st_eff == rrtp_pkg::ST_RUNNING)) begin
      st_we    = 1'b1;
      st_waddr = cur_addr;
      st_wdata = rrtp_pkg::ST_READY;
    end else if (cmd.scan && hit) begin
      st_we    = 1'b1;
      st_waddr = scan_idx_r;
      st_wdata = rrtp_pkg::ST_RUNNING;
    end

    cnt_we    = 1'b0;
    cnt_waddr = sig_slot_r;
    cnt_wdata = cnt_eff + rrtp_pkg::CNT_W'(1);
    priority if (cmd.cnt_inc && sig_ok_r && (cnt_eff != '1)) begin
      cnt_we = 1'b1;
    end else if (cmd.scan && dec) begin
      cnt_we    = 1'b1;
      cnt_waddr = scan_idx_r;
      cnt_wdata = cnt_eff - rrtp_pkg::CNT_W'(1);
    end

    tim_we    = cmd.slot_wr && in_slot_ok && (nst_norm == rrtp_pkg::ST_WAIT_TIMEOUT);
    tim_wdata = {tick_r, in_data.wait_timeout};

    sts.cur_valid = cur_valid_r;
    sts.hit       = hit;
    sts.last      = scan_cnt_r == rrtp_pkg::SLOT_W'(rrtp_pkg::SLOTS - 1);
    sts.out_full  = out_valid_r && !out_ready;
  end

  always_comb begin
    idle_slot_nxt = cfg_we ? cfg_data : idle_slot_r;
    tick_nxt      = cmd.tick_inc ? tick_r + rrtp_pkg::TICK_W'(1) : tick_r;

    st_vld_nxt = st_vld_r;
    if (st_we) begin
      st_vld_nxt[st_waddr] = 1'b1;
    end
    cnt_vld_nxt = cnt_vld_r;
    if (cnt_we) begin
      cnt_vld_nxt[cnt_waddr] = 1'b1;
    end

    sig_slot_nxt = cmd.cnt_rd ? in_addr : sig_slot_r;
    sig_ok_nxt   = cmd.cnt_rd ? in_slot_ok : sig_ok_r;

    scan_idx_nxt = scan_idx_r;
    scan_cnt_nxt = scan_cnt_r;
    if (cmd.demote) begin
      scan_idx_nxt = start_addr;
      scan_cnt_nxt = '0;
    end else if (cmd.scan) begin
      scan_idx_nxt = next_idx;
      scan_cnt_nxt = scan_cnt_r + rrtp_pkg::SLOT_W'(1);
    end

    pick_nxt  = pick_r;
    found_nxt = found_r;
    if (cmd.no_cur || (cmd.scan && !hit && sts.last)) begin
      pick_nxt  = idle_slot_r;
      found_nxt = 1'b0;
    end else if (cmd.scan && hit) begin
      pick_nxt  = rrtp_pkg::ID_W'(scan_idx_r);
      found_nxt = 1'b1;
    end

    out_valid_nxt = cmd.push || (out_valid_r && !out_ready);
    out_data_nxt  = out_data_r;
    cur_slot_nxt  = cur_slot_r;
    cur_valid_nxt = cur_valid_r;
    if (cmd.push) begin
      out_data_nxt.picked_slot = pick_r;
      out_data_nxt.went_idle   = !found_r;
      cur_slot_nxt             = pick_r;
      cur_valid_nxt            = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idle_slot_r <= '0;
      cur_slot_r  <= '0;
      cur_valid_r <= 1'b0;
      tick_r      <= '0;
      st_vld_r    <= '0;
      cnt_vld_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      idle_slot_r <= idle_slot_nxt;
      cur_slot_r  <= cur_slot_nxt;
      cur_valid_r <= cur_valid_nxt;
      tick_r      <= tick_nxt;
      st_vld_r    <= st_vld_nxt;
      cnt_vld_r   <= cnt_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    st_vld_q_r  <= st_vld_r[rd_addr];
    cnt_vld_q_r <= cnt_vld_r[rd_addr];
    scan_idx_r  <= scan_idx_nxt;
    scan_cnt_r  <= scan_cnt_nxt;
    sig_slot_r  <= sig_slot_nxt;
    sig_ok_r    <= sig_ok_nxt;
    pick_r      <= pick_nxt;
    found_r     <= found_nxt;
    out_data_r  <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `RRTP_ASSERT_NEXT(a_push_loads_out, cmd.push, out_valid_r)
  `RRTP_ASSERT_NEXT(a_push_sets_cur, cmd.push, cur_valid_r && (cur_slot_r == out_data_r.picked_slot))
  `RRTP_ASSERT_NEXT(a_hit_records_pick, cmd.scan && hit, found_r && (pick_r == rrtp_pkg::ID_W'($past(scan_idx_r))))
  `RRTP_ASSERT_IMPL(a_scan_has_current, cmd.scan || cmd.demote, cur_valid_r)

endmodule

FILE: src/round_robin_thread_picker.sv
// Tick and slot write complete in the idle state; an event signal reads the count, then
// increments it in the signal state. Schedule goes straight to done with no current thread,
// else through demote and a circular scan of 1 to SLOTS slots, one slot table read per cycle.
// A finished result waits in the output register while other transactions are taken.
// Reset (synchronous, rst_n low) clears slot valid bits, tick, current slot and
// idle_slot at once; no clearing pass is needed.
// ---------------------------------------------------------------------------
// Round robin thread picker
// Picks the next runnable thread slot with event waits and timeouts.
// ---------------------------------------------------------------------------
module round_robin_thread_picker (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  rrtp_pkg::in_item_t        in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output rrtp_pkg::out_item_t       out_data,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [rrtp_pkg::ID_W-1:0] cfg_data
);

  rrtp_pkg::cmd_t cmd;
  rrtp_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  rrtp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_mode  (in_data.mode),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  rrtp_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .cfg_we    (cfg_valid),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Round robin thread picker testbench
// Drives tick, slot write, event signal and schedule transactions through the
// valid/ready input channel and checks every pick against a local model of
// the slot table, with random stalls on both sides and idle slot changes.
// ---------------------------------------------------------------------------
module testbench;

  localparam rrtp_pkg::slot_state_t ST_BAD_LO = 3'd6;
  localparam rrtp_pkg::slot_state_t ST_BAD_HI = 3'd7;
  localparam int SETTLE_CYCLES  = 2 * rrtp_pkg::SLOTS;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int RX_HOLD_CYCLES = 400;
  localparam int PHASE_ITEMS    = 360;
  localparam int EVT_SIGNALS    = 4;

  logic                          clk       = 1'b0;
  logic                          rst_n     = 1'b0;
  logic                          in_valid  = 1'b0;
  logic                          in_ready;
  rrtp_pkg::in_item_t            in_data   = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  rrtp_pkg::out_item_t           out_data;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [rrtp_pkg::ID_W-1:0]     cfg_data  = '0;

  rrtp_pkg::in_item_t            pending_items[$];
  rrtp_pkg::out_item_t           picks_due[$];
  int                            tx_idle_pct  = 12;
  int                            rx_idle_pct  = 55;
  int                            rx_hold_left = 0;
  int                            quiet_cycles = 0;
  int                            mismatches   = 0;
  logic [rrtp_pkg::ID_W-1:0]     hot_base     = '0;

  // picker model state
  rrtp_pkg::slot_state_t         slot_st[rrtp_pkg::SLOTS];
  logic [rrtp_pkg::CNT_W-1:0]    slot_events[rrtp_pkg::SLOTS];
  logic [rrtp_pkg::TICK_W-1:0]   slot_wait_from[rrtp_pkg::SLOTS];
  logic [rrtp_pkg::TMO_W-1:0]    slot_wait_len[rrtp_pkg::SLOTS];
  logic [rrtp_pkg::TICK_W-1:0]   ticks;
  logic [rrtp_pkg::ID_W-1:0]     cur_slot;
  logic                          cur_valid;
  logic [rrtp_pkg::ID_W-1:0]     idle_slot_reg;

  round_robin_thread_picker dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    $display("%0t ns mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task automatic clear_picker();
    for (int i = 0; i < rrtp_pkg::SLOTS; i++) begin
      slot_st[i]        = rrtp_pkg::ST_EMPTY;
      slot_events[i]    = '0;
      slot_wait_from[i] = '0;
      slot_wait_len[i]  = '0;
    end
    ticks         = '0;
    cur_slot      = '0;
    cur_valid     = 1'b0;
    idle_slot_reg = '0;
  endtask

  function automatic bit claim_slot(input int s);
    logic [rrtp_pkg::TICK_W-1:0] waited;
    if (slot_st[s] == rrtp_pkg::ST_READY) return 1'b1;
    if (slot_st[s] == rrtp_pkg::ST_WAIT_EVENT || slot_st[s] == rrtp_pkg::ST_WAIT_TIMEOUT) begin
      if (slot_events[s] != '0) begin
        slot_events[s] = slot_events[s] - rrtp_pkg::CNT_W'(1);
        return 1'b1;
      end
      waited = ticks - slot_wait_from[s];
      if (slot_st[s] == rrtp_pkg::ST_WAIT_TIMEOUT && waited >= slot_wait_len[s]) return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic schedule_pick();
    rrtp_pkg::out_item_t res;
    bit                  found;
    int                  s;
    int                  k;
    found           = 1'b0;
    res.picked_slot = idle_slot_reg;
    if (cur_valid) begin
      if (cur_slot != idle_slot_reg && slot_st[cur_slot] == rrtp_pkg::ST_RUNNING)
        slot_st[cur_slot] = rrtp_pkg::ST_READY;
      for (k = 0; k < rrtp_pkg::SLOTS && !found; k++) begin
        s = (int'(cur_slot) + 1 + k) % rrtp_pkg::SLOTS;
        if (claim_slot(s)) begin
          found           = 1'b1;
          res.picked_slot = rrtp_pkg::ID_W'(s);
        end
      end
    end
    if (found) slot_st[res.picked_slot] = rrtp_pkg::ST_RUNNING;
    cur_slot      = res.picked_slot;
    cur_valid     = 1'b1;
    res.went_idle = !found;
    picks_due.push_back(res);
  endtask

  task automatic apply_transaction(input rrtp_pkg::in_item_t it);
    rrtp_pkg::slot_state_t st;
    case (it.mode)
      rrtp_pkg::MODE_TICK: ticks = ticks + rrtp_pkg::TICK_W'(1);
      rrtp_pkg::MODE_WRITE: begin
        st = it.new_state;
        if (st > rrtp_pkg::ST_WAIT_TIMEOUT) st = rrtp_pkg::ST_EMPTY;
        slot_st[it.slot] = st;
        if (st == rrtp_pkg::ST_WAIT_TIMEOUT) begin
          slot_wait_from[it.slot] = ticks;
          slot_wait_len[it.slot]  = it.wait_timeout;
        end
      end
      rrtp_pkg::MODE_SIGNAL: begin
        if (slot_events[it.slot] != '1)
          slot_events[it.slot] = slot_events[it.slot] + rrtp_pkg::CNT_W'(1);
      end
      default: schedule_pick();
    endcase
  endtask

  function automatic rrtp_pkg::in_item_t mk_item(input rrtp_pkg::mode_t m, input int s,
                                                 input rrtp_pkg::slot_state_t st,
                                                 input logic [rrtp_pkg::TMO_W-1:0] tmo);
    rrtp_pkg::in_item_t it;
    it.mode         = m;
    it.slot         = rrtp_pkg::ID_W'(s);
    it.new_state    = st;
    it.wait_timeout = tmo;
    return it;
  endfunction

  function automatic rrtp_pkg::in_item_t random_item();
    rrtp_pkg::in_item_t it;
    int                 r;
    r = $urandom_range(99);
    if (r < 30)      it.mode = rrtp_pkg::MODE_TICK;
    else if (r < 58) it.mode = rrtp_pkg::MODE_WRITE;
    else if (r < 78) it.mode = rrtp_pkg::MODE_SIGNAL;
    else             it.mode = rrtp_pkg::MODE_SCHED;
    if ($urandom_range(99) < 65) it.slot = rrtp_pkg::ID_W'(hot_base + $urandom_range(7));
    else                         it.slot = rrtp_pkg::ID_W'($urandom_range(rrtp_pkg::SLOTS - 1));
    r = $urandom_range(99);
    if (r < 25)      it.new_state = rrtp_pkg::ST_READY;
    else if (r < 45) it.new_state = rrtp_pkg::ST_WAIT_EVENT;
    else if (r < 65) it.new_state = rrtp_pkg::ST_WAIT_TIMEOUT;
    else             it.new_state = rrtp_pkg::slot_state_t'($urandom_range(7));
    r = $urandom_range(99);
    if (r < 70)      it.wait_timeout = rrtp_pkg::TMO_W'($urandom_range(24));
    else if (r < 80) it.wait_timeout = '1;
    else             it.wait_timeout = rrtp_pkg::TMO_W'($urandom());
    return it;
  endfunction

  task automatic push_random(input int n);
    @(negedge clk);
    repeat (n) pending_items.push_back(random_item());
  endtask

  task automatic drain_and_settle();
    while (pending_items.size() != 0 || in_valid || picks_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_idle_slot(input logic [rrtp_pkg::ID_W-1:0] v);
    @(posedge clk);
    cfg_data  <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(negedge clk);
    hot_base = v - rrtp_pkg::ID_W'(3);
  endtask

  task automatic set_idling(input int tx_pct, input int rx_pct);
    @(negedge clk);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
  endtask

  // sender
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data  <= '0;
    end else if (!in_valid || in_ready) begin
      if (pending_items.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        in_data  <= pending_items.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (rx_hold_left > 0) begin
      out_ready <= 1'b0;
      rx_hold_left = rx_hold_left - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // result check, then model update for accepted transactions
  always @(posedge clk) begin
    rrtp_pkg::out_item_t want;
    if (!rst_n) begin
      clear_picker();
    end else begin
      if (out_valid && out_ready) begin
        if (picks_due.size() == 0) begin
          report_mismatch($sformatf("unexpected pick slot %0d went_idle %0b",
                                    out_data.picked_slot, out_data.went_idle));
        end else begin
          want = picks_due.pop_front();
          if (out_data.picked_slot !== want.picked_slot)
            report_mismatch($sformatf("picked_slot %0d, expected %0d",
                                      out_data.picked_slot, want.picked_slot));
          if (out_data.went_idle !== want.went_idle)
            report_mismatch($sformatf("went_idle %0b, expected %0b",
                                      out_data.went_idle, want.went_idle));
        end
      end
      if (cfg_valid && cfg_ready) idle_slot_reg = cfg_data;
      if (in_valid && in_ready) apply_transaction(in_data);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [rrtp_pkg::ID_W-1:0] idle_c;
    logic [rrtp_pkg::ID_W-1:0] evt_slot;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    write_idle_slot('0);

    @(negedge clk);
    pending_items.push_back(mk_item(rrtp_pkg::MODE_SCHED,  0,  rrtp_pkg::ST_EMPTY,  '0));
    pending_items.push_back(mk_item(rrtp_pkg::MODE_WRITE,  0,  rrtp_pkg::ST_READY,  '0));
    pending_items.push_back(mk_item(rrtp_pkg::MODE_WRITE,  63, rrtp_pkg::ST_WAIT_EVENT, '0));
    pending_items.push_back(mk_item(rrtp_pkg::MODE_SIGNAL, 63, rrtp_pkg::ST_EMPTY,  '0));
    pending_items.push_back(mk_item(rrtp_pkg::MODE_WRITE,  10, rrtp_pkg::ST_WAIT_TIMEOUT, '0));
    pending_items.push_back(mk_item(rrtp_pkg::MODE_WRITE,  20, ST_BAD_LO,           '0));
    pending_items.push_back(mk_item(rrtp_pkg::MODE_WRITE,  21, ST_BAD_HI,           '1));
    pending_items.push_back(mk_item(rrtp_pkg::MODE_WRITE,  30, rrtp_pkg::ST_BLOCKED, '0));
    pending_items.push_back(mk_item(rrtp_pkg::MODE_WRITE,  31, rrtp_pkg::ST_RUNNING, '0));
    pending_items.push_back(mk_item(rrtp_pkg::MODE_SCHED,  0,  rrtp_pkg::ST_EMPTY,  '0));
    pending_items.push_back(mk_item(rrtp_pkg::MODE_SCHED,  63, ST_BAD_HI,           '1));
    pending_items.push_back(mk_item(rrtp_pkg::MODE_SCHED,  0,  rrtp_pkg::ST_EMPTY,  '0));
    pending_items.push_back(mk_item(rrtp_pkg::MODE_WRITE,  40, rrtp_pkg::ST_WAIT_TIMEOUT, '1));
    pending_items.push_back(mk_item(rrtp_pkg::MODE_WRITE,  10, rrtp_pkg::ST_EMPTY,  '0));
    pending_items.push_back(mk_item(rrtp_pkg::MODE_WRITE,  63, rrtp_pkg::ST_EMPTY,  '0));
    pending_items.push_back(mk_item(rrtp_pkg::MODE_WRITE,  0,  rrtp_pkg::ST_RUNNING, '0));
    pending_items.push_back(mk_item(rrtp_pkg::MODE_SCHED,  0,  rrtp_pkg::ST_EMPTY,  '0));
    pending_items.push_back(mk_item(rrtp_pkg::MODE_TICK,   0,  rrtp_pkg::ST_EMPTY,  '0));
    pending_items.push_back(mk_item(rrtp_pkg::MODE_WRITE,  50, rrtp_pkg::ST_WAIT_TIMEOUT,
                                    rrtp_pkg::TMO_W'(2)));
    pending_items.push_back(mk_item(rrtp_pkg::MODE_TICK,   63, ST_BAD_HI,           '1));
    pending_items.push_back(mk_item(rrtp_pkg::MODE_SCHED,  0,  rrtp_pkg::ST_EMPTY,  '0));
    pending_items.push_back(mk_item(rrtp_pkg::MODE_TICK,   0,  rrtp_pkg::ST_EMPTY,  '0));
    pending_items.push_back(mk_item(rrtp_pkg::MODE_SCHED,  0,  rrtp_pkg::ST_EMPTY,  '0));
    pending_items.push_back(mk_item(rrtp_pkg::MODE_SIGNAL, 40, rrtp_pkg::ST_EMPTY,  '0));
    pending_items.push_back(mk_item(rrtp_pkg::MODE_SCHED,  0,  rrtp_pkg::ST_EMPTY,  '0));
    drain_and_settle();

    // sender lightly idle, receiver mostly stalled; long hold fills the block
    write_idle_slot('1);
    @(negedge clk);
    rx_hold_left = RX_HOLD_CYCLES;
    push_random(PHASE_ITEMS / 2);
    drain_and_settle();
    push_random(PHASE_ITEMS / 2);
    drain_and_settle();

    write_idle_slot(rrtp_pkg::ID_W'($urandom_range(1, rrtp_pkg::SLOTS - 2)));
    set_idling(55, 12);
    push_random(PHASE_ITEMS);
    drain_and_settle();

    idle_c = rrtp_pkg::ID_W'($urandom_range(rrtp_pkg::SLOTS - 1));
    write_idle_slot(idle_c);
    set_idling(0, 0);
    push_random(PHASE_ITEMS);

    // pending events on an otherwise empty table
    evt_slot = idle_c ^ 6'h20;
    @(negedge clk);
    for (int i = 0; i < rrtp_pkg::SLOTS; i++)
      pending_items.push_back(mk_item(rrtp_pkg::MODE_WRITE, i, rrtp_pkg::ST_EMPTY, '0));
    pending_items.push_back(mk_item(rrtp_pkg::MODE_WRITE, int'(evt_slot),
                                    rrtp_pkg::ST_WAIT_EVENT, '0));
    repeat (EVT_SIGNALS)
      pending_items.push_back(mk_item(rrtp_pkg::MODE_SIGNAL, int'(evt_slot),
                                      rrtp_pkg::ST_EMPTY, '0));
    pending_items.push_back(mk_item(rrtp_pkg::MODE_SCHED, 0, rrtp_pkg::ST_EMPTY, '0));
    pending_items.push_back(mk_item(rrtp_pkg::MODE_SCHED, 0, rrtp_pkg::ST_EMPTY, '0));
    drain_and_settle();

    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: round_robin_thread_picker.f
+incdir+src
src/rrtp_pkg.sv
src/rrtp_ram.sv
src/rrtp_ctrl.sv
src/rrtp_dp.sv
src/round_robin_thread_picker.sv
tb/sv/testbench.sv
